// File: src/crc32il_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// CRC-32 checked interleaved loader package
// Shared beat types, CRC constants, status codes and register indexes.
// ============================================================================
package crc32il_pkg;

    localparam int DATA_W   = 8;
    localparam int OUT_AW   = 20;
    localparam int INDEX_W  = 21;
    localparam int CRC_W    = 32;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 8;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [CRC_W-1:0]   CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]   CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [INDEX_W-1:0] INDEX_MAX    = 21'h1F_FFFF;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PASS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CRC = 2'd3;

    // Register indexes; register i sits at byte address 4*i.
    localparam logic [REG_IDX_W-1:0] REG_ROM_OFFSET      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTERLEAVE_STEP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EXPECTED_CRC    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_LENGTH    = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } item_beat_t;

    typedef struct packed {
        logic                write_enable;
        logic [OUT_AW-1:0]   write_address;
        logic [DATA_W-1:0]   write_data;
        logic                image_done;
        logic [STATUS_W-1:0] check_status;
        logic [CRC_W-1:0]    found_crc;
    } result_beat_t;

endpackage

// File: src/crc32_checked_interleaved_loader.sv
`timescale 1ns / 1ps
// ============================================================================
// CRC-32 checked interleaved loader
// Streams image bytes out as staged interleaved writes and checks the image
// length and reflected CRC-32 on the last byte.
// ============================================================================
// The loader takes one image byte per beat and returns exactly one result
// beat for it, carrying the byte, its destination address
// (rom_offset + index * interleave_step, wrapped to ADDR_BITS bits) and a
// write enable that is low for bytes beyond the image length register. On
// the beat marked last_byte the result also carries image_done, the check
// status (pass, wrong length, or wrong checksum, where wrong length wins
// when both are wrong) and the final CRC found; the consumer should treat
// the writes as staged and commit them only on pass. The block sustains one
// beat per clock while the result side does not stall: a beat is captured
// in an input register, and from there a single byte-wise CRC update plus
// an address add and the length compare load the result register. The
// input stalls only when both registers hold a beat and the result side
// is stalling. After the last byte the running CRC, byte count and address
// stride return to their start values for the next image; the registers
// keep their contents. Registers are written through the APB port and
// should only be changed while no image beat is in flight.
// ============================================================================
module crc32_checked_interleaved_loader
    import crc32il_pkg::*;
#(
    parameter int ADDR_BITS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_stall,
    input  item_beat_t          item,

    output logic                result_valid,
    input  logic                result_stall,
    output result_beat_t        result,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [OUT_AW-1:0]  rom_offset_reg;
    logic [STEP_W-1:0]  interleave_step_reg;
    logic [CRC_W-1:0]   expected_crc_reg;
    logic [INDEX_W-1:0] image_length_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_offset_reg      <= '0;
            interleave_step_reg <= STEP_W'(1);
            expected_crc_reg    <= '0;
            image_length_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ROM_OFFSET:      rom_offset_reg      <= pwdata[OUT_AW-1:0];
                REG_INTERLEAVE_STEP: interleave_step_reg <= pwdata[STEP_W-1:0];
                REG_EXPECTED_CRC:    expected_crc_reg    <= pwdata[CRC_W-1:0];
                REG_IMAGE_LENGTH:    image_length_reg    <= pwdata[INDEX_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROM_OFFSET:      prdata = {{(PDATA_W-OUT_AW){1'b0}}, rom_offset_reg};
            REG_INTERLEAVE_STEP: prdata = {{(PDATA_W-STEP_W){1'b0}}, interleave_step_reg};
            REG_EXPECTED_CRC:    prdata = expected_crc_reg;
            REG_IMAGE_LENGTH:    prdata = {{(PDATA_W-INDEX_W){1'b0}}, image_length_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and pipeline control
    // ------------------------------------------------------------------
    item_beat_t   item_reg;
    logic         item_valid_reg;
    logic         advance;
    logic         result_valid_reg;
    result_beat_t result_reg;

    // The captured beat moves into the result register whenever that
    // register is empty or its beat is being taken this cycle.
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    // ------------------------------------------------------------------
    // Image state: running CRC, byte index, address stride
    // ------------------------------------------------------------------
    logic [CRC_W-1:0]     crc_accum_reg;
    logic [INDEX_W-1:0]   byte_index_reg;
    logic [ADDR_BITS-1:0] stride_sum_reg;

    logic [CRC_W-1:0]     crc_next;
    logic [INDEX_W:0]     byte_count;
    logic [ADDR_BITS-1:0] offset_trim;
    logic [ADDR_BITS-1:0] addr_full;
    logic [31:0]          addr_wide;
    logic [CRC_W-1:0]     found;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_BITS-1:0] stride_sum_next;
    logic [INDEX_W-1:0]   byte_index_next;

    crc32il_crc_byte u_crc_byte
    (
        .crc_in  (crc_accum_reg),
        .data    (item_reg.data_byte),
        .crc_out (crc_next)
    );

    assign offset_trim = ADDR_BITS'({{(32-OUT_AW){1'b0}}, rom_offset_reg});
    assign addr_full   = offset_trim + stride_sum_reg;
    assign addr_wide   = 32'(addr_full);
    assign byte_count  = {1'b0, byte_index_reg} + (INDEX_W+1)'(1);
    assign found       = crc_next ^ CRC_ALL_ONES;

    always_comb
    begin
        if (!item_reg.last_byte)
        begin
            status = STATUS_BUSY;
        end
        else if (byte_count != {1'b0, image_length_reg})
        begin
            status = STATUS_BAD_LEN;
        end
        else if (found != expected_crc_reg)
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_PASS;
        end
    end

    assign stride_sum_next = stride_sum_reg + ADDR_BITS'(interleave_step_reg);
    assign byte_index_next = (byte_index_reg < INDEX_MAX) ?
                             byte_index_reg + INDEX_W'(1) : byte_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_accum_reg  <= CRC_ALL_ONES;
            byte_index_reg <= '0;
            stride_sum_reg <= '0;
        end
        else if (advance)
        begin
            if (item_reg.last_byte)
            begin
                // Image finished: start over for the next one.
                crc_accum_reg  <= CRC_ALL_ONES;
                byte_index_reg <= '0;
                stride_sum_reg <= '0;
            end
            else
            begin
                crc_accum_reg  <= crc_next;
                byte_index_reg <= byte_index_next;
                stride_sum_reg <= stride_sum_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || !result_stall)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.write_enable  <= byte_index_reg < image_length_reg;
            result_reg.write_address <= addr_wide[OUT_AW-1:0];
            result_reg.write_data    <= item_reg.data_byte;
            result_reg.image_done    <= item_reg.last_byte;
            result_reg.check_status  <= status;
            result_reg.found_crc     <= item_reg.last_byte ? found : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_held_beat_stays: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("captured beat dropped while the result side was stalled");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.last_byte |=>
            (byte_index_reg == '0) && (crc_accum_reg == CRC_ALL_ONES) &&
            (stride_sum_reg == '0))
        else $error("image state not cleared after the last byte");

    a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.image_done |-> result.check_status != STATUS_BUSY)
        else $error("last-byte result carries no check status");

    a_busy_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.image_done |->
            (result.check_status == STATUS_BUSY) && (result.found_crc == '0))
        else $error("mid-image result carries a status or a CRC");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(byte_index_reg) && $stable(crc_accum_reg))
        else $error("image state moved without a beat");

endmodule

// File: src/crc32il_crc_byte.sv
`timescale 1ns / 1ps
// ============================================================================
// CRC-32 byte update
// Folds one byte into a reflected CRC-32 register (polynomial 0xEDB88320).
// ============================================================================
module crc32il_crc_byte
    import crc32il_pkg::*;
(
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [DATA_W-1:0] data,
    output logic [CRC_W-1:0]  crc_out
);

    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
        // Eight shift-and-reduce steps, one per data bit, LSB first.
        for (int k = 0; k < DATA_W; k++)
        begin
            if (c[0])
            begin
                c = CRC_POLY ^ (c >> 1);
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
